// File: rtl/core/huffman_code_builder_unit_defines.svh
// ------------------------------------------------------------------------
// huffman code builder assertion macros
// shared property wrappers for the port checker
// ------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcb port check failed");

// next-cycle implication, sampled on clk, off during reset
`define HCB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcb port check failed");

`endif

// File: rtl/core/hcb_pkg.sv
// ------------------------------------------------------------------------
// hcb_pkg
// sizes, types and state codes of the huffman code builder
// ------------------------------------------------------------------------
package hcb_pkg;

	localparam int NUM_SYMBOLS = 8;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_COUNT  = 2 * NUM_SYMBOLS - 1;
	localparam int IDX_W       = $clog2(2 * NUM_SYMBOLS);
	localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);
	localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
	localparam int SUM_W       = WEIGHT_BITS + $clog2(NUM_SYMBOLS);
	localparam int LOAD_W      = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int LEN_W       = 3;
	localparam int CODE_W      = 7;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SUM_W-1:0] sum_t;

	// no-child marker, above the highest node index
	localparam idx_t NO_CHILD = {IDX_W{1'b1}};

	// running minimum passed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
		idx_t idx;
		sum_t weight;
	} token_t;

	// node store commands broadcast to every cell
	typedef struct packed {
		logic wr;
		idx_t wr_idx;
		sum_t wr_weight;
		idx_t wr_left;
		idx_t wr_right;
		logic deact;
		idx_t deact_idx;
		logic clear;
	} node_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_MERGE,
		ST_WALK,
		ST_CLEAR
	} state_t;

endpackage

// File: rtl/core/huffman_code_builder_unit.sv
// ------------------------------------------------------------------------
// huffman_code_builder_unit
// loads weighted symbols, builds a huffman tree in a cell chain and
// reports the code of every leaf in depth-first order
// ------------------------------------------------------------------------
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------
//  input    | symbol, weight, last_symbol                  | start & !busy
//  result   | leaf_symbol, code_length, code_bits, last_code | code_valid strobe
//
// loading accepts one item per cycle while the block is not busy. each of
// the k-1 merges runs two minimum scans through the NODE_COUNT cells of the
// chain plus one write step; the walk then visits every node of the tree and
// a clearing step follows. busy is high from the last item until the block
// is ready again. reset clears all control state and the node links.
// results cannot be stalled.
module huffman_code_builder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] symbol,
	input  logic [15:0] weight,
	input  logic       last_symbol,
	output logic       code_valid,
	output logic [7:0] leaf_symbol,
	output logic [2:0] code_length,
	output logic [6:0] code_bits,
	output logic       last_code
);
	import hcb_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0] load_cnt_q;
	idx_t             n_q;
	idx_t             end_idx_q;
	logic             pick_b_q;
	idx_t             a_idx_q;
	sum_t             a_w_q;
	idx_t             b_idx_q;
	sum_t             b_w_q;

	idx_t             cur_q;
	logic [LEN_W-1:0] depth_q;
	logic [CODE_W-1:0] code_q;
	logic [CNT_W-1:0] sp_q;
	idx_t             stk_node_q  [NUM_SYMBOLS];
	logic [LEN_W-1:0] stk_depth_q [NUM_SYMBOLS];
	logic [CODE_W-1:0] stk_code_q [NUM_SYMBOLS];
	logic [7:0]       sym_q [NUM_SYMBOLS];

	logic             out_valid_q;
	logic [7:0]       out_sym_q;
	logic [LEN_W-1:0] out_len_q;
	logic [CODE_W-1:0] out_code_q;
	logic             out_last_q;

	node_cmd_t        cmd;
	logic             launch;
	token_t           scan;
	idx_t [NODE_COUNT-1:0] node_left;
	idx_t [NODE_COUNT-1:0] node_right;

	logic             accept;
	logic             build;
	logic             is_leaf;
	logic             merge_done;

	hcb_node_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.launch (launch),
		.result (scan),
		.left   (node_left),
		.right  (node_right)
	);

	assign accept     = start && (state_q == ST_IDLE);
	assign build      = last_symbol || (load_cnt_q == CNT_W'(NUM_SYMBOLS - 1));
	assign is_leaf    = (node_left[cur_q] == NO_CHILD) && (node_right[cur_q] == NO_CHILD);
	assign merge_done = (n_q == end_idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && build) begin
					state_d = (load_cnt_q == '0) ? ST_WALK : ST_LAUNCH;
				end
			end
			ST_LAUNCH: state_d = ST_WAIT;
			ST_WAIT: begin
				if (scan.valid) begin
					state_d = pick_b_q ? ST_MERGE : ST_LAUNCH;
				end
			end
			ST_MERGE: state_d = merge_done ? ST_WALK : ST_LAUNCH;
			ST_WALK: begin
				if (is_leaf && (sp_q == '0)) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// node commands and scan launch
	always_comb begin
		cmd    = '0;
		launch = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr        = accept;
				cmd.wr_idx    = IDX_W'(load_cnt_q);
				cmd.wr_weight = SUM_W'(weight[LOAD_W-1:0]);
				cmd.wr_left   = NO_CHILD;
				cmd.wr_right  = NO_CHILD;
			end
			ST_LAUNCH: launch = 1'b1;
			ST_WAIT: begin
				cmd.deact     = scan.valid;
				cmd.deact_idx = scan.idx;
			end
			ST_MERGE: begin
				cmd.wr        = 1'b1;
				cmd.wr_idx    = n_q;
				cmd.wr_weight = a_w_q + b_w_q;
				cmd.wr_left   = a_idx_q;
				cmd.wr_right  = b_idx_q;
			end
			ST_WALK: ;
			ST_CLEAR: cmd.clear = 1'b1;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// load count, merge bookkeeping and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			n_q        <= '0;
			end_idx_q  <= '0;
			pick_b_q   <= 1'b0;
			cur_q      <= '0;
			depth_q    <= '0;
			code_q     <= '0;
			sp_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						n_q        <= IDX_W'(load_cnt_q) + 1'b1;
						end_idx_q  <= IDX_W'({load_cnt_q, 1'b0});
						pick_b_q   <= 1'b0;
						cur_q      <= '0;
						depth_q    <= '0;
						code_q     <= '0;
						sp_q       <= '0;
					end
				end
				ST_LAUNCH: ;
				ST_WAIT: begin
					if (scan.valid) begin
						pick_b_q <= !pick_b_q;
					end
				end
				ST_MERGE: begin
					n_q <= n_q + 1'b1;
					if (merge_done) begin
						cur_q <= n_q;
					end
				end
				ST_WALK: begin
					if (is_leaf) begin
						if (sp_q != '0) begin
							sp_q    <= sp_q - 1'b1;
							cur_q   <= stk_node_q[sp_q[SYM_IDX_W-1:0] - 1'b1];
							depth_q <= stk_depth_q[sp_q[SYM_IDX_W-1:0] - 1'b1];
							code_q  <= stk_code_q[sp_q[SYM_IDX_W-1:0] - 1'b1];
						end
					end else begin
						sp_q    <= sp_q + 1'b1;
						cur_q   <= node_left[cur_q];
						depth_q <= depth_q + 1'b1;
						code_q  <= {code_q[CODE_W-2:0], 1'b0};
					end
				end
				ST_CLEAR: load_cnt_q <= '0;
				default: ;
			endcase
		end
	end

	// payload: symbols, picked nodes and pending right branches
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q[load_cnt_q[SYM_IDX_W-1:0]] <= symbol;
		end
		if ((state_q == ST_WAIT) && scan.valid) begin
			if (pick_b_q) begin
				b_idx_q <= scan.idx;
				b_w_q   <= scan.weight;
			end else begin
				a_idx_q <= scan.idx;
				a_w_q   <= scan.weight;
			end
		end
		if ((state_q == ST_WALK) && !is_leaf) begin
			stk_node_q[sp_q[SYM_IDX_W-1:0]]  <= node_right[cur_q];
			stk_depth_q[sp_q[SYM_IDX_W-1:0]] <= depth_q + 1'b1;
			stk_code_q[sp_q[SYM_IDX_W-1:0]]  <= {code_q[CODE_W-2:0], 1'b1};
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == ST_WALK) && is_leaf;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_WALK) && is_leaf) begin
			out_sym_q  <= sym_q[cur_q[SYM_IDX_W-1:0]];
			out_len_q  <= depth_q;
			out_code_q <= code_q;
			out_last_q <= (sp_q == '0);
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign code_valid  = out_valid_q;
	assign leaf_symbol = out_sym_q;
	assign code_length = out_len_q;
	assign code_bits   = out_code_q;
	assign last_code   = out_last_q;

endmodule

// File: rtl/core/hcb_cell.sv
// ------------------------------------------------------------------------
// hcb_cell
// one tree node: weight, children, active flag and one minimum-scan step
// ------------------------------------------------------------------------
module hcb_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  hcb_pkg::idx_t      cell_idx,
	input  hcb_pkg::node_cmd_t cmd,
	input  hcb_pkg::token_t    tok_in,
	output hcb_pkg::token_t    tok_out,
	output hcb_pkg::idx_t      left,
	output hcb_pkg::idx_t      right
);
	import hcb_pkg::*;

	logic   active_q;
	sum_t   weight_q;
	idx_t   left_q;
	idx_t   right_q;
	token_t tok_q;
	token_t tok_d;
	logic   take;

	// take over the minimum when active and strictly lighter, or when none is found yet
	always_comb begin
		take  = tok_in.valid && active_q && (!tok_in.found || (weight_q < tok_in.weight));
		tok_d = tok_in;
		if (take) begin
			tok_d.found  = 1'b1;
			tok_d.idx    = cell_idx;
			tok_d.weight = weight_q;
		end
	end

	// scan token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// node control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= NO_CHILD;
			right_q  <= NO_CHILD;
		end else if (cmd.clear) begin
			active_q <= 1'b0;
			left_q   <= NO_CHILD;
			right_q  <= NO_CHILD;
		end else begin
			if (cmd.wr && (cmd.wr_idx == cell_idx)) begin
				active_q <= 1'b1;
				left_q   <= cmd.wr_left;
				right_q  <= cmd.wr_right;
			end
			if (cmd.deact && (cmd.deact_idx == cell_idx)) begin
				active_q <= 1'b0;
			end
		end
	end

	// node weight, read only while active
	always_ff @(posedge clk) begin
		if (cmd.wr && (cmd.wr_idx == cell_idx)) begin
			weight_q <= cmd.wr_weight;
		end
	end

	assign tok_out = tok_q;
	assign left    = left_q;
	assign right   = right_q;

endmodule

// File: rtl/core/hcb_node_chain.sv
// ------------------------------------------------------------------------
// hcb_node_chain
// row of node cells; the scan token moves one cell per cycle
// ------------------------------------------------------------------------
module hcb_node_chain (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hcb_pkg::node_cmd_t                    cmd,
	input  logic                                  launch,
	output hcb_pkg::token_t                       result,
	output hcb_pkg::idx_t [hcb_pkg::NODE_COUNT-1:0] left,
	output hcb_pkg::idx_t [hcb_pkg::NODE_COUNT-1:0] right
);
	import hcb_pkg::*;

	token_t tok [NODE_COUNT+1];

	// fresh token enters the first cell
	assign tok[0] = '{valid: launch, found: 1'b0, idx: '0, weight: '0};

	// cells in index order so ties go to the lower index
	for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
		hcb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.cmd      (cmd),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.left     (left[i]),
			.right    (right[i])
		);
	end

	assign result = tok[NODE_COUNT];

endmodule

// File: rtl/core/hcb_port_checker.sv
// ------------------------------------------------------------------------
// hcb_port_checker
// port-level checks of the huffman code builder, bound to the top level
// ------------------------------------------------------------------------
`include "huffman_code_builder_unit_defines.svh"

module hcb_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       code_valid,
	input logic [2:0] code_length,
	input logic       last_code
);

	// results only come while the block is building
	`HCB_ASSERT_IMP(a_result_busy, code_valid, busy)

	// an accepted item never yields a result in the next cycle
	`HCB_ASSERT_NXT(a_accept_quiet, start && !busy, !code_valid)

	// the last code is followed by a ready block and no further item
	`HCB_ASSERT_NXT(a_last_ends, code_valid && last_code, !code_valid && !busy)

	// only a lone symbol reports a zero length
	`HCB_ASSERT_IMP(a_len_nonzero, code_valid && (code_length == 3'd0), last_code)

endmodule

bind huffman_code_builder_unit hcb_port_checker u_hcb_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.code_valid  (code_valid),
	.code_length (code_length),
	.last_code   (last_code)
);

// File: dv/huffman_code_builder_unit_test.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// huffman_code_builder_unit_test
// feeds symbol sets to the code builder, predicts the huffman code of each
// leaf in depth-first order and checks every code item as it is reported
// ------------------------------------------------------------------------
module huffman_code_builder_unit_test;
	import hcb_pkg::*;

	localparam int MAX_NODES = 2 * NUM_SYMBOLS - 1;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [7:0] sym;
		logic [2:0] len;
		logic [6:0] bits;
		logic       last;
	} code_item_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  symbol;
	logic [15:0] weight;
	logic        last_symbol;
	logic        code_valid;
	logic [7:0]  leaf_symbol;
	logic [2:0]  code_length;
	logic [6:0]  code_bits;
	logic        last_code;

	huffman_code_builder_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.symbol(symbol), .weight(weight), .last_symbol(last_symbol),
		.code_valid(code_valid), .leaf_symbol(leaf_symbol),
		.code_length(code_length), .code_bits(code_bits), .last_code(last_code)
	);

	// predictor copy of the node store
	logic [31:0] tree_weight [MAX_NODES];
	int          tree_left   [MAX_NODES];
	int          tree_right  [MAX_NODES];
	logic [7:0]  tree_sym    [NUM_SYMBOLS];
	bit          tree_live   [MAX_NODES];
	int          loaded;

	code_item_t expected_codes [$];
	int  mismatches;
	int  idle_pct;
	int  quiet_cycles;
	bit  timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_tree();
		for (int i = 0; i < MAX_NODES; i++) begin
			tree_weight[i] = '0;
			tree_left[i] = -1;
			tree_right[i] = -1;
			tree_live[i] = 1'b0;
		end
		loaded = 0;
	endfunction

	function automatic int pop_lightest(int lim);
		int best;
		bit found;
		best = 0;
		found = 1'b0;
		for (int i = 0; i < lim; i++)
			if (tree_live[i] && (!found || tree_weight[i] < tree_weight[best])) begin
				best = i;
				found = 1'b1;
			end
		tree_live[best] = 1'b0;
		return best;
	endfunction

	// depth-first, left branch is bit 0
	function automatic void walk_codes(int x, int depth, logic [6:0] code);
		code_item_t c;
		if (tree_left[x] < 0 && tree_right[x] < 0) begin
			c.sym = (x < NUM_SYMBOLS) ? tree_sym[x] : 8'd0;
			c.len = depth[2:0];
			c.bits = code;
			c.last = 1'b0;
			expected_codes.push_back(c);
			return;
		end
		walk_codes(tree_left[x], depth + 1, {code[5:0], 1'b0});
		walk_codes(tree_right[x], depth + 1, {code[5:0], 1'b1});
	endfunction

	function automatic void predict_codes(logic [7:0] s, logic [15:0] w, logic lst);
		int n, k, a, b;
		tree_sym[loaded] = s;
		tree_weight[loaded] = {16'd0, w};
		tree_left[loaded] = -1;
		tree_right[loaded] = -1;
		tree_live[loaded] = 1'b1;
		loaded++;
		if (!lst && loaded < NUM_SYMBOLS)
			return;
		k = loaded;
		n = k;
		for (int m = 0; m + 1 < k; m++) begin
			a = pop_lightest(n);
			b = pop_lightest(n);
			tree_left[n] = a;
			tree_right[n] = b;
			tree_weight[n] = tree_weight[a] + tree_weight[b];
			tree_live[n] = 1'b1;
			n++;
		end
		walk_codes(n - 1, 0, 7'd0);
		expected_codes[$].last = 1'b1;
		clear_tree();
	endfunction

	// check each reported code item
	always @(posedge clk) begin
		code_item_t e;
		if (arst_n && code_valid) begin
			if (expected_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected code item sym=%0d len=%0d bits=%b",
						leaf_symbol, code_length, code_bits);
			end else begin
				e = expected_codes.pop_front();
				if (leaf_symbol !== e.sym || code_length !== e.len ||
						code_bits !== e.bits || last_code !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"code mismatch exp sym=%0d len=%0d bits=%b last=%b",
							" got sym=%0d len=%0d bits=%b last=%b"},
							e.sym, e.len, e.bits, e.last,
							leaf_symbol, code_length, code_bits, last_code);
				end
			end
		end
	end

	// watchdog on cycles without any accepted item or reported code
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || code_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// start stays high after the accepting edge; drain or an idle gap in the next call lowers it
	task automatic send_item(logic [7:0] s, logic [15:0] w, logic lst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		symbol <= s;
		weight <= w;
		last_symbol <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_codes(s, w, lst);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic send_set(int cnt, bit flag_last, int wmax);
		for (int i = 0; i < cnt; i++)
			send_item(8'($urandom_range(255)), 16'($urandom_range(wmax)),
				flag_last && i == cnt - 1);
	endtask

	// full sets, extreme weights and ties
	task automatic test_full_sets();
		for (int i = 0; i < NUM_SYMBOLS; i++)
			send_item(8'(i), 16'hFFFF, 1'b0);
		for (int i = 0; i < NUM_SYMBOLS; i++)
			send_item(8'(255 - i), 16'(1 << (2 * i)), i == NUM_SYMBOLS - 1);
		drain();
	endtask

	// early last flag and a lone symbol
	task automatic test_short_sets();
		send_item(8'hA5, 16'h0000, 1'b1);
		send_item(8'h00, 16'h0000, 1'b0);
		send_item(8'hFF, 16'h0000, 1'b1);
		send_item(8'h5A, 16'h1234, 1'b0);
		send_item(8'h3C, 16'h0001, 1'b0);
		send_item(8'hC3, 16'h8000, 1'b1);
		drain();
	endtask

	task automatic test_random_sets();
		int total;
		total = 0;
		while (total < 380) begin
			int cnt;
			cnt = $urandom_range(1, NUM_SYMBOLS);
			if ($urandom_range(9) == 0)
				send_set(cnt, 1'b0, 65535);
			else
				send_set(cnt, cnt < NUM_SYMBOLS || $urandom_range(1),
					$urandom_range(3) == 0 ? 3 : 65535);
			total += cnt;
			if (total > 100 && total < 140) idle_pct = 0;
			else idle_pct = 24;
		end
		drain();
	endtask

	initial begin
		mismatches = 0;
		timed_out = 1'b0;
		idle_pct = 24;
		clear_tree();
		arst_n = 1'b0;
		start = 1'b0;
		symbol = '0;
		weight = '0;
		last_symbol = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_sets();
		test_short_sets();
		test_random_sets();
		// a set left open has no results pending; close it to flush
		if (loaded != 0) begin
			send_item(8'h11, 16'h0002, 1'b1);
			drain();
		end
		if (mismatches == 0 && expected_codes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
